// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/bds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int DATA_W          = 32;
    localparam int EXP_W           = 4;
    localparam int TC_W            = 9;
    localparam int ADDR_W          = 3;
    localparam int MAX_EXPONENT_DEF = 9;

    localparam logic [DATA_W-1:0] BASE_RESET     = 32'd9830400;
    localparam logic [DATA_W-1:0] QUOTIENT_STOP  = 32'd128;
    localparam logic [DATA_W-1:0] QUOTIENT_MAX   = 32'd255;
    localparam logic [TC_W-1:0]   CONSTANT_CLAMP = 9'd256;

    // Register index codes
    localparam logic REG_BASE_CLOCK = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] requested_rate;
        logic              use_line_clock;
    } in_t;

    typedef struct packed {
        logic [7:0]        time_constant;
        logic [EXP_W-1:0]  rate_exponent;
        logic              line_clock_selected;
        logic [DATA_W-1:0] achieved_rate;
        logic              bad_request;
    } out_t;

    // First divider: base / rate
    typedef struct packed {
        logic              line;
        logic              bad;
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } a_stage_t;

    // Second divider: base / time constant
    typedef struct packed {
        logic              line;
        logic              bad;
        logic [EXP_W-1:0]  expo;
        logic [TC_W-1:0]   tc;
        logic [TC_W-1:0]   rem;
        logic [DATA_W-1:0] quo;
    } b_stage_t;

endpackage

`default_nettype wire

// File: hdl/baud_divisor_select.sv
`timescale 1ns / 1ps
`default_nettype none
// Baud divisor selection.
// Input channel (s_valid/s_ready/s_data): one transaction carries a requested
// bit rate and the line clock flag. Result channel (m_valid/m_ready/m_data):
// one transaction per input with time constant (0 means 256), prescaler
// exponent, line clock select, achieved rate and bad request flag.
// The base clock register sits at byte address 0 of the APB port.
// A 32-stage restoring divider forms base / rate, one stage picks exponent
// and constant, a second 32-stage divider forms base / constant, and an
// output register holds the result. One bit of quotient is resolved per
// stage, so a new transaction may enter each cycle unless the receiver stalls.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and s_ready drops, nothing is lost.
// Reset clears all stage valid bits and loads the base clock with 9830400.
// Write the base clock only while no transaction is in flight.
module baud_divisor_select #(
    parameter int MAX_EXPONENT = bds_pkg::MAX_EXPONENT_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire bds_pkg::in_t          s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output bds_pkg::out_t              m_data,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [bds_pkg::ADDR_W-1:0]  paddr,
    input  wire [bds_pkg::DATA_W-1:0]  pwdata,
    output logic [bds_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bds_pkg::*;

    logic [DATA_W-1:0] base_reg;
    logic              adv;
    logic              m_valid_reg;
    out_t              m_data_reg;

    // Configuration port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BASE_CLOCK)) begin
            base_reg <= pwdata;
        end
    end
    assign prdata = (paddr[2] == REG_BASE_CLOCK) ? base_reg : '0;

    // Global advance
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Divider A: base / rate
    wire       a_v  [0:DATA_W];
    wire a_stage_t a_st [0:DATA_W];

    assign a_v[0]       = s_valid;
    assign a_st[0].line = s_data.use_line_clock;
    assign a_st[0].bad  = !s_data.use_line_clock && (s_data.requested_rate == '0);
    assign a_st[0].rate = s_data.requested_rate;
    assign a_st[0].rem  = '0;
    assign a_st[0].quo  = '0;

    for (genvar i = 0; i < DATA_W; i++) begin : g_div_a
        logic          v_reg;
        a_stage_t      st_reg;
        a_stage_t      st_next;
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        logic          ge;

        always_comb begin
            trial   = {a_st[i].rem, base_reg[DATA_W-1-i]};
            diff    = trial - {1'b0, a_st[i].rate};
            ge      = (trial >= {1'b0, a_st[i].rate});
            st_next = a_st[i];
            st_next.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            st_next.quo = {a_st[i].quo[DATA_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (adv) begin
                v_reg <= a_v[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg <= st_next;
            end
        end

        assign a_v[i+1]  = v_reg;
        assign a_st[i+1] = st_reg;
    end

    // Exponent and time constant selection
    logic [EXP_W-1:0]  e_sel;
    logic [DATA_W-1:0] q_sel;
    b_stage_t          sel_next;
    logic              sel_v_reg;
    b_stage_t          sel_reg;

    always_comb begin
        e_sel = EXP_W'(1);
        for (int k = 1; k <= MAX_EXPONENT; k++) begin
            if ((a_st[DATA_W].quo >> k) > QUOTIENT_STOP) begin
                e_sel = EXP_W'(k);
            end
        end
        q_sel         = a_st[DATA_W].quo >> e_sel;
        sel_next.line = a_st[DATA_W].line;
        sel_next.bad  = a_st[DATA_W].bad;
        sel_next.rem  = '0;
        sel_next.quo  = '0;
        if (a_st[DATA_W].line || a_st[DATA_W].bad || (q_sel == '0)) begin
            sel_next.expo = '0;
            sel_next.tc   = TC_W'(1);
        end else if (q_sel > QUOTIENT_MAX) begin
            sel_next.expo = e_sel;
            sel_next.tc   = CONSTANT_CLAMP;
        end else begin
            sel_next.expo = e_sel;
            sel_next.tc   = q_sel[TC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_v_reg <= 1'b0;
        end else if (adv) begin
            sel_v_reg <= a_v[DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sel_reg <= sel_next;
        end
    end

    // Divider B: base / time constant
    wire       b_v  [0:DATA_W];
    wire b_stage_t b_st [0:DATA_W];

    assign b_v[0]  = sel_v_reg;
    assign b_st[0] = sel_reg;

    for (genvar j = 0; j < DATA_W; j++) begin : g_div_b
        logic          v_reg;
        b_stage_t      st_reg;
        b_stage_t      st_next;
        logic [TC_W:0] trial;
        logic [TC_W:0] diff;
        logic          ge;

        always_comb begin
            trial   = {b_st[j].rem, base_reg[DATA_W-1-j]};
            diff    = trial - {1'b0, b_st[j].tc};
            ge      = (trial >= {1'b0, b_st[j].tc});
            st_next = b_st[j];
            st_next.rem = ge ? diff[TC_W-1:0] : trial[TC_W-1:0];
            st_next.quo = {b_st[j].quo[DATA_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (adv) begin
                v_reg <= b_v[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg <= st_next;
            end
        end

        assign b_v[j+1]  = v_reg;
        assign b_st[j+1] = st_reg;
    end

    // Output register
    out_t m_data_next;
    always_comb begin
        m_data_next.time_constant       = b_st[DATA_W].tc[7:0];
        m_data_next.rate_exponent       = b_st[DATA_W].expo;
        m_data_next.line_clock_selected = b_st[DATA_W].line;
        m_data_next.bad_request         = b_st[DATA_W].bad;
        m_data_next.achieved_rate       = (b_st[DATA_W].line || b_st[DATA_W].bad) ?
                                          '0 : (b_st[DATA_W].quo >> b_st[DATA_W].expo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= b_v[DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: hdl/bds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bds_checker #(
    parameter int MAX_EXPONENT = bds_pkg::MAX_EXPONENT_DEF
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_ready,
    input wire                m_valid,
    input wire                m_ready,
    input wire bds_pkg::out_t m_data
);
    import bds_pkg::*;

    // A waiting result holds while the receiver stalls
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The pipeline refuses input only while a result is stalled
    `ASSERT_IMPLY(a_ready, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // Line clock results carry the fixed settings
    `ASSERT_IMPLY(a_line, aclk, aresetn, m_valid && m_data.line_clock_selected,
        m_data.time_constant == 8'd1 && m_data.rate_exponent == '0 &&
        m_data.achieved_rate == '0 && !m_data.bad_request)

    // Bad request results carry no rate
    `ASSERT_IMPLY(a_bad, aclk, aresetn, m_valid && m_data.bad_request,
        m_data.achieved_rate == '0 && m_data.time_constant == 8'd1 &&
        m_data.rate_exponent == '0)

    // Exponent stays within its range
    `ASSERT_IMPLY(a_exp, aclk, aresetn, m_valid,
        m_data.rate_exponent <= EXP_W'(MAX_EXPONENT))

endmodule

bind baud_divisor_select bds_checker #(.MAX_EXPONENT(MAX_EXPONENT)) u_bds_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
